@@ src/mapcs_pkg.sv @@
package mapcs_pkg;

  // field widths
  localparam int CMD_W   = 2;
  localparam int CH_W    = 3;
  localparam int POS_W   = 21;
  localparam int DWELL_W = 16;
  localparam int STAT_W  = 2;
  localparam int THR_W   = 16;
  localparam int TIME_W  = 32;
  localparam int ENTRY_W = POS_W + DWELL_W;

  // default sizing
  localparam int DEF_AXES        = 6;
  localparam int DEF_QUEUE_DEPTH = 16;

  // threshold register reset value
  localparam logic [THR_W-1:0] THRESHOLD_RESET = 16'd20;

  // register index decoded from the address
  localparam logic REG_THRESHOLD = 1'b0;

  // command codes
  localparam logic [CMD_W-1:0] CMD_ENQUEUE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_UPDATE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK    = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NOP     = 2'd3;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_INVALID = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;

  // controller to datapath commands
  typedef struct packed {
    logic capture;
    logic exec;
  } ctrl_cmd_t;

endpackage

@@ src/mapcs_ctrl.sv @@
module mapcs_ctrl import mapcs_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output ctrl_cmd_t cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state;
  logic state_next;

  // handshake decode
  assign in_ready    = (state == S_IDLE);
  assign cmd.capture = in_valid && in_ready;
  assign cmd.exec    = (state == S_EXEC) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd.capture) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (cmd.exec) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.exec) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_accept_to_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> state == S_EXEC)
    else $error("accepted item did not enter execute");
  a_exec_gives_result: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |=> out_valid)
    else $error("execute did not present a result");
  a_result_from_exec: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_EXEC)
    else $error("result appeared without execute");
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC) && !cmd.exec |=> state == S_EXEC)
    else $error("stalled item left execute");
`endif

endmodule

@@ src/mapcs_datapath.sv @@
module mapcs_datapath import mapcs_pkg::*; #(
  parameter int AXES        = DEF_AXES,
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  ctrl_cmd_t          cmd,
  input  logic [THR_W-1:0]   threshold,
  input  logic [CMD_W-1:0]   command,
  input  logic [CH_W-1:0]    channel,
  input  logic [POS_W-1:0]   goal_position,
  input  logic [DWELL_W-1:0] dwell_ms,
  input  logic [POS_W-1:0]   measured_position,
  output logic [STAT_W-1:0]  status,
  output logic [CH_W-1:0]    out_channel,
  output logic               issue_valid,
  output logic [POS_W-1:0]   issued_position,
  output logic               reached,
  output logic               dwell_done,
  output logic               is_moving,
  output logic               is_dwelling,
  output logic               queue_empty
);

  localparam int AW = (AXES > 1) ? $clog2(AXES) : 1;
  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int MW = $clog2(AXES * QUEUE_DEPTH);
  localparam logic [PW-1:0] PTR_LAST = PW'(QUEUE_DEPTH - 1);

  // per-axis state
  logic [PW-1:0]      head_ptr      [AXES];
  logic [PW-1:0]      tail_ptr      [AXES];
  logic [POS_W-1:0]   target_pos    [AXES];
  logic [DWELL_W-1:0] dwell_len     [AXES];
  logic [TIME_W-1:0]  dwell_start   [AXES];
  logic               moving_flag   [AXES];
  logic               dwelling_flag [AXES];
  logic [TIME_W-1:0]  now_ms;

  // goal queue storage, all axes
  logic [ENTRY_W-1:0] goal_store [AXES * QUEUE_DEPTH];
  logic [ENTRY_W-1:0] rd_data;

  // captured item and axis snapshot
  logic [CMD_W-1:0]   cmd_r;
  logic [CH_W-1:0]    ch_r;
  logic [POS_W-1:0]   goal_r;
  logic [DWELL_W-1:0] dwell_r;
  logic [POS_W-1:0]   meas_r;
  logic [PW-1:0]      head_r;
  logic [PW-1:0]      tail_r;
  logic [POS_W-1:0]   target_r;
  logic [DWELL_W-1:0] dlen_r;
  logic [TIME_W-1:0]  dstart_r;
  logic               mov_r;
  logic               dwl_r;

  logic [AW-1:0] ax_in;
  logic [AW-1:0] ax;
  logic [MW-1:0] rd_addr;
  logic [MW-1:0] wr_addr;

  assign ax_in   = channel[AW-1:0];
  assign ax      = ch_r[AW-1:0];
  assign rd_addr = MW'(ax_in) * MW'(QUEUE_DEPTH) + MW'(head_ptr[ax_in]);
  assign wr_addr = MW'(ax) * MW'(QUEUE_DEPTH) + MW'(tail_r);

  // execute-cycle results
  logic               chan_ok;
  logic [PW-1:0]      tail_inc;
  logic [PW-1:0]      head_inc;
  logic               pop;
  logic [POS_W-1:0]   tgt;
  logic [DWELL_W-1:0] dlen;
  logic [POS_W:0]     diff;
  logic [POS_W:0]     mag;
  logic               close;
  logic [TIME_W-1:0]  elapsed;
  logic               dwell_over;
  logic               mem_we;
  logic [STAT_W-1:0]  st_n;
  logic               iv_n;
  logic               rch_n;
  logic               dd_n;
  logic [PW-1:0]      head_n;
  logic [PW-1:0]      tail_n;
  logic               mov_n;
  logic               dwl_n;
  logic               start_we;

  // capture item and axis state
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r    <= command;
      ch_r     <= channel;
      goal_r   <= goal_position;
      dwell_r  <= dwell_ms;
      meas_r   <= measured_position;
      head_r   <= head_ptr[ax_in];
      tail_r   <= tail_ptr[ax_in];
      target_r <= target_pos[ax_in];
      dlen_r   <= dwell_len[ax_in];
      dstart_r <= dwell_start[ax_in];
      mov_r    <= moving_flag[ax_in];
      dwl_r    <= dwelling_flag[ax_in];
    end
  end

  // queue memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (cmd.exec && mem_we) begin
      goal_store[wr_addr] <= {goal_r, dwell_r};
    end
    if (cmd.capture) begin
      rd_data <= goal_store[rd_addr];
    end
  end

  // pointer increments and arithmetic
  assign chan_ok  = ({1'b0, ch_r} < (CH_W + 1)'(AXES));
  assign tail_inc = (tail_r == PTR_LAST) ? '0 : tail_r + 1'b1;
  assign head_inc = (head_r == PTR_LAST) ? '0 : head_r + 1'b1;
  assign pop      = !mov_r && !dwl_r && (head_r != tail_r);
  assign tgt      = pop ? rd_data[ENTRY_W-1 -: POS_W] : target_r;
  assign dlen     = pop ? rd_data[DWELL_W-1:0] : dlen_r;
  assign diff     = {tgt[POS_W-1], tgt} - {meas_r[POS_W-1], meas_r};
  assign mag      = diff[POS_W] ? (~diff + 1'b1) : diff;
  assign close    = (mag <= (POS_W + 1)'(threshold));
  assign elapsed  = now_ms - dstart_r;
  assign dwell_over = (elapsed >= TIME_W'(dlen_r));

  // next axis state and result fields
  always_comb begin
    st_n     = ST_OK;
    iv_n     = 1'b0;
    rch_n    = 1'b0;
    dd_n     = 1'b0;
    head_n   = head_r;
    tail_n   = tail_r;
    mov_n    = mov_r;
    dwl_n    = dwl_r;
    mem_we   = 1'b0;
    start_we = 1'b0;
    case (cmd_r)
      CMD_ENQUEUE: begin
        if (!chan_ok) begin
          st_n = ST_INVALID;
        end else if (tail_inc == head_r) begin
          st_n = ST_FULL;
        end else begin
          mem_we = 1'b1;
          tail_n = tail_inc;
        end
      end
      CMD_UPDATE: begin
        if (!chan_ok) begin
          st_n = ST_INVALID;
        end else begin
          if (pop) begin
            iv_n   = 1'b1;
            head_n = head_inc;
            mov_n  = 1'b1;
          end
          if ((mov_r || pop) && close) begin
            mov_n = 1'b0;
            rch_n = 1'b1;
            if (dlen != '0) begin
              dwl_n    = 1'b1;
              start_we = 1'b1;
            end
          end else if (dwl_r && dwell_over) begin
            dwl_n = 1'b0;
            dd_n  = 1'b1;
          end
        end
      end
      default: begin
        st_n = ST_OK;
      end
    endcase
  end

  // per-axis state and millisecond counter
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < AXES; i++) begin
        head_ptr[i]      <= '0;
        tail_ptr[i]      <= '0;
        target_pos[i]    <= '0;
        dwell_len[i]     <= '0;
        dwell_start[i]   <= '0;
        moving_flag[i]   <= 1'b0;
        dwelling_flag[i] <= 1'b0;
      end
      now_ms <= '0;
    end else if (cmd.exec) begin
      if (cmd_r == CMD_TICK) begin
        now_ms <= now_ms + 1'b1;
      end
      if (chan_ok) begin
        head_ptr[ax]      <= head_n;
        tail_ptr[ax]      <= tail_n;
        target_pos[ax]    <= tgt;
        dwell_len[ax]     <= dlen;
        moving_flag[ax]   <= mov_n;
        dwelling_flag[ax] <= dwl_n;
        if (start_we) begin
          dwell_start[ax] <= now_ms;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status          <= st_n;
      out_channel     <= ch_r;
      issue_valid     <= iv_n;
      issued_position <= iv_n ? tgt : '0;
      reached         <= rch_n;
      dwell_done      <= dd_n;
      is_moving       <= chan_ok && mov_n;
      is_dwelling     <= chan_ok && dwl_n;
      queue_empty     <= chan_ok && (head_n == tail_n) && !dwl_n;
    end
  end

`ifndef SYNTHESIS
  for (genvar g = 0; g < AXES; g++) begin : g_axis_chk
    a_one_phase: assert property (@(posedge clk) disable iff (rst)
      !(moving_flag[g] && dwelling_flag[g]))
      else $error("axis moving and dwelling at once");
    a_ptr_range: assert property (@(posedge clk) disable iff (rst)
      (head_ptr[g] <= PTR_LAST) && (tail_ptr[g] <= PTR_LAST))
      else $error("queue pointer beyond depth");
    a_dwell_len: assert property (@(posedge clk) disable iff (rst)
      dwelling_flag[g] |-> dwell_len[g] != '0)
      else $error("dwelling with zero dwell length");
  end
`endif

endmodule

@@ src/multi_axis_position_command_sequencer_unit.sv @@
// an accepted item is captured with its queue read; its result is registered when it executes
// a new item is not accepted until the previous one has executed (capture with queue read, then execute)
// an unread result stalls only the execute cycle of the following item
// reset (synchronous, rst high): queue pointers, axis flags, dwell state and the
// millisecond counter clear, threshold returns to 20; queue storage is not cleared
module multi_axis_position_command_sequencer_unit import mapcs_pkg::*; #(
  parameter int AXES        = DEF_AXES,
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [CMD_W-1:0]   command,
  input  logic [CH_W-1:0]    channel,
  input  logic [POS_W-1:0]   goal_position,
  input  logic [DWELL_W-1:0] dwell_ms,
  input  logic [POS_W-1:0]   measured_position,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [STAT_W-1:0]  status,
  output logic [CH_W-1:0]    out_channel,
  output logic               issue_valid,
  output logic [POS_W-1:0]   issued_position,
  output logic               reached,
  output logic               dwell_done,
  output logic               is_moving,
  output logic               is_dwelling,
  output logic               queue_empty
);

  ctrl_cmd_t        cmd;
  logic [THR_W-1:0] reach_limit;

  // configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_THRESHOLD) ? 32'(reach_limit) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      reach_limit <= THRESHOLD_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_THRESHOLD)) begin
      reach_limit <= pwdata[THR_W-1:0];
    end
  end

  mapcs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  mapcs_datapath #(
    .AXES        (AXES),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .threshold         (reach_limit),
    .command           (command),
    .channel           (channel),
    .goal_position     (goal_position),
    .dwell_ms          (dwell_ms),
    .measured_position (measured_position),
    .status            (status),
    .out_channel       (out_channel),
    .issue_valid       (issue_valid),
    .issued_position   (issued_position),
    .reached           (reached),
    .dwell_done        (dwell_done),
    .is_moving         (is_moving),
    .is_dwelling       (is_dwelling),
    .queue_empty       (queue_empty)
  );

endmodule
